@@ design/shnt_pkg.sv @@
// Shared types, constants and codes of the spatial hash neighbour table.
package shnt_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int MAX_RESULTS = 64;
  localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int BUCKET_W    = 16;
  localparam int ID_W        = 10;
  localparam int LIMIT_W     = 7;
  localparam int POS_W       = 32;
  localparam int INV_W       = 24;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int ENTRY_W     = BUCKET_W + ID_W;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [31:0] PRIME_X = 32'd73856093;
  localparam logic [31:0] PRIME_Y = 32'd19349663;
  localparam logic [31:0] PRIME_Z = 32'd83492791;

  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd1;

  localparam logic [INV_W-1:0]    INV_CELL_RESET   = 24'd163840;
  localparam logic [BUCKET_W-1:0] TABLE_SIZE_RESET = 16'd2053;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_NEIGHBOUR = 3'd0,
    ST_NONE      = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [ID_W-1:0]    particle_id;
    logic [LIMIT_W-1:0] limit;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] neighbour_id;
    logic [2:0]      status;
    logic            last;
  } out_item_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic [1:0]          action;
    logic [BUCKET_W-1:0] bucket;
    logic [ID_W-1:0]     particle_id;
    logic [LIMIT_W-1:0]  limit;
  } cmd_t;

endpackage

@@ design/shnt_ram.sv @@
// Generic single-port-write, registered-read RAM.
module shnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/shnt_fifo.sv @@
// Short command queue between front and back.
module shnt_fifo import shnt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o,
  output logic empty_o
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  cmd_t          slot_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o    = (cnt_q == CW'(FIFO_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

endmodule

@@ design/shnt_front.sv @@
// Front end: accepts items and computes the hash bucket of their position for insert and query.
module shnt_front import shnt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  input  logic [INV_W-1:0]    inv_cell_i,
  input  logic [BUCKET_W-1:0] table_size_i,
  output logic                push_o,
  output cmd_t                push_cmd_o,
  input  logic                full_i
);

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_PRIME, F_MOD, F_PUSH} fstate_e;

  fstate_e                 state_q;
  in_item_t                item_q;
  logic [1:0]              k_q;
  logic signed [56:0]      prod_q;
  logic [31:0]             hash_q;
  logic [31:0]             div_q;
  logic [BUCKET_W-1:0]     rem_q;
  logic [4:0]              bit_q;

  logic signed [31:0]      coord;
  logic signed [56:0]      prod_d;
  logic [31:0]             cell_idx;
  logic [31:0]             prime;
  logic [BUCKET_W-1:0]     modulus;
  logic [BUCKET_W:0]       trial;
  logic [BUCKET_W-1:0]     rem_d;
  logic [LIMIT_W-1:0]      lim_sat;

  always_comb begin
    case (k_q)
      2'd0:    begin coord = item_q.pos_x; prime = PRIME_X; end
      2'd1:    begin coord = item_q.pos_y; prime = PRIME_Y; end
      default: begin coord = item_q.pos_z; prime = PRIME_Z; end
    endcase
  end

  assign prod_d   = coord * $signed({1'b0, inv_cell_i});
  // floor of the product over 2^32, sign extended
  assign cell_idx = {{7{prod_q[56]}}, prod_q[56:32]};
  assign modulus  = (table_size_i == '0) ? BUCKET_W'(1) : table_size_i;
  assign trial    = {rem_q, div_q[31]};
  assign rem_d    = (trial >= {1'b0, modulus}) ? BUCKET_W'(trial - {1'b0, modulus})
                                               : trial[BUCKET_W-1:0];
  assign lim_sat  = (item_q.limit > LIMIT_W'(MAX_RESULTS)) ? LIMIT_W'(MAX_RESULTS)
                                                           : item_q.limit;

  assign in_stall_o = (state_q != F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;

  always_comb begin
    push_cmd_o.action      = item_q.action;
    push_cmd_o.bucket      = rem_q;
    push_cmd_o.particle_id = item_q.particle_id;
    push_cmd_o.limit       = lim_sat;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          item_q <= in_item_i;
          k_q    <= '0;
          hash_q <= '0;
          rem_q  <= '0;
        end
      end
      F_MUL:   prod_q <= prod_d;
      F_PRIME: begin
        hash_q <= hash_q ^ (cell_idx * prime);
        k_q    <= k_q + 1'b1;
        div_q  <= hash_q ^ (cell_idx * prime);
      end
      F_MOD: begin
        rem_q <= rem_d;
        div_q <= {div_q[30:0], 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      bit_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            case (in_item_i.action)
              ACT_CLEAR:              state_q <= F_PUSH;
              ACT_INSERT, ACT_QUERY:  state_q <= F_MUL;
              default:                state_q <= F_IDLE;  // drop unused code
            endcase
          end
        end
        F_MUL:   state_q <= F_PRIME;
        F_PRIME: begin
          bit_q   <= '0;
          state_q <= (k_q == 2'd2) ? F_MOD : F_MUL;
        end
        F_MOD: begin
          bit_q <= bit_q + 1'b1;
          if (bit_q == 5'd31) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

@@ design/shnt_back.sv @@
// Back end: executes clear, insert and query against the entry memory.
module shnt_back import shnt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic {B_IDLE, B_SCAN} bstate_e;

  bstate_e             state_q;
  logic [COUNT_W-1:0]  count_q;
  logic [COUNT_W-1:0]  idx_q;
  logic [LIMIT_W-1:0]  n_q, lim_q;
  logic [BUCKET_W-1:0] key_q;
  logic                pend_q, hit_q;
  logic [ID_W-1:0]     hit_id_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic                go, match, issue, flush, emit, we;
  logic [LIMIT_W-1:0]  n_add;
  out_item_t           emit_item;
  logic [ENTRY_W-1:0]  rdata;

  shnt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[ENTRY_AW-1:0]),
    .wdata_i ({cmd_i.bucket, cmd_i.particle_id}),
    .re_i    (issue),
    .raddr_i (idx_q[ENTRY_AW-1:0]),
    .rdata_o (rdata)
  );

  assign go    = !out_valid_q || !out_stall_i;
  assign match = pend_q && (rdata[ENTRY_W-1:ID_W] == key_q);
  assign n_add = n_q + LIMIT_W'(match);

  always_comb begin
    pop_o     = 1'b0;
    we        = 1'b0;
    issue     = 1'b0;
    flush     = 1'b0;
    emit      = 1'b0;
    emit_item = '{neighbour_id: '0, status: ST_NONE, last: 1'b1};
    case (state_q)
      B_IDLE: begin
        if (go && !empty_i) begin
          pop_o = 1'b1;
          case (cmd_i.action)
            ACT_CLEAR: begin
              emit             = 1'b1;
              emit_item.status = ST_CLEARED;
            end
            ACT_INSERT: begin
              emit             = 1'b1;
              we               = !count_q[COUNT_W-1];
              emit_item.status = count_q[COUNT_W-1] ? ST_FULL : ST_INSERTED;
            end
            default: ;
          endcase
        end
      end
      B_SCAN: begin
        if (go) begin
          issue = (idx_q < count_q) && (n_add < lim_q);
          flush = !pend_q && ((idx_q == count_q) || (n_q >= lim_q));
          // hold the newest hit back until it is known whether it is the final one
          if (match && hit_q) begin
            emit      = 1'b1;
            emit_item = '{neighbour_id: hit_id_q, status: ST_NEIGHBOUR, last: 1'b0};
          end else if (flush) begin
            emit = 1'b1;
            if (hit_q) begin
              emit_item = '{neighbour_id: hit_id_q, status: ST_NEIGHBOUR, last: 1'b1};
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= emit_item;
    end
    if (state_q == B_IDLE) begin
      key_q <= cmd_i.bucket;
      lim_q <= cmd_i.limit;
    end
    // keep the held hit while the output is stalled
    if (match && go) begin
      hit_id_q <= rdata[ID_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= emit || (out_valid_q && out_stall_i);
      case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            case (cmd_i.action)
              ACT_CLEAR:  count_q <= '0;
              ACT_INSERT: if (we) count_q <= count_q + 1'b1;
              ACT_QUERY: begin
                state_q <= B_SCAN;
                idx_q   <= '0;
                n_q     <= '0;
                pend_q  <= 1'b0;
                hit_q   <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        B_SCAN: begin
          if (go) begin
            n_q    <= n_add;
            pend_q <= issue;
            if (issue) begin
              idx_q <= idx_q + 1'b1;
            end
            if (match) begin
              hit_q <= 1'b1;
            end
            if (flush) begin
              state_q <= B_IDLE;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

@@ design/spatial_hash_neighbour_table_unit.sv @@
// Top level of the spatial hash neighbour table.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): one transaction per
// action: clear, insert a particle id at a position, or query the ids stored
// in the bucket of a position. Output channel (out_valid_o / out_stall_i /
// out_item_o): every action yields one or more result transactions, the
// final one flagged with last; an unused action code yields none.
// The front hashes a position (three cell multiplies, three prime
// multiplies, a 32-step remainder) and takes a new item when that is
// done and the two-deep command queue has room; clear skips the hash.
// The back runs clear and insert straight from idle. A query reads one
// stored entry per cycle from the entry memory while the output is not
// stalled, up to the 1024 entries of a full table or its limit.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) land on the next
// clock edge; the user must write only while idle; the block does not check.
// Reset empties the table and loads the default cell size and table size.
// A stalled output holds its result; the back then pauses, the queue fills,
// and in_stall_o stays high once the front can push no more.
module spatial_hash_neighbour_table_unit import shnt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic [INV_W-1:0]    inv_cell_q;
  logic [BUCKET_W-1:0] table_size_q;
  logic                push, full, pop, empty;
  cmd_t                push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_cell_q   <= INV_CELL_RESET;
      table_size_q <= TABLE_SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_INV_CELL:   inv_cell_q   <= cfg_wdata_i[INV_W-1:0];
        REG_TABLE_SIZE: table_size_q <= cfg_wdata_i[BUCKET_W-1:0];
        default: ;
      endcase
    end
  end

  shnt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .inv_cell_i   (inv_cell_q),
    .table_size_i (table_size_q),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .full_i       (full)
  );

  shnt_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (empty)
  );

  shnt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ design/shnt_checker.sv @@
// Port-level checker for the spatial hash neighbour table, bound to the top.
module shnt_checker import shnt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_NEIGHBOUR) |-> out_item_o.last)
    else $error("non-neighbour result without last");

  a_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_NEIGHBOUR) |-> out_item_o.neighbour_id == '0)
    else $error("non-neighbour result carries an id");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status <= ST_CLEARED)
    else $error("status code out of range");

endmodule

bind spatial_hash_neighbour_table_unit shnt_checker u_shnt_checker (.*);

@@ sim/spatial_hash_neighbour_table_unit_tb.sv @@
// Testbench for the spatial hash neighbour table: random and directed actions vs a predictor.
`timescale 1ns / 1ps

module spatial_hash_neighbour_table_unit_tb;
  import shnt_pkg::*;

  int unsigned err_count = 0;

  task automatic report(input string what, input out_item_t got, input out_item_t want);
    $display("mismatch %s: got id=%0d st=%0d last=%0d, want id=%0d st=%0d last=%0d",
             what, got.neighbour_id, got.status, got.last,
             want.neighbour_id, want.status, want.last);
    err_count++;
  endtask

  class table_scoreboard;
    logic [INV_W-1:0]    inv_cell;
    logic [BUCKET_W-1:0] tbl_size;
    logic [BUCKET_W-1:0] bucket_mem [MAX_ENTRIES];
    logic [ID_W-1:0]     ident_mem [MAX_ENTRIES];
    int unsigned         n_stored;
    out_item_t           pending [$];

    function new();
      inv_cell = INV_CELL_RESET;
      tbl_size = TABLE_SIZE_RESET;
      n_stored = 0;
    endfunction

    function automatic logic [31:0] cell_index(logic signed [31:0] coord);
      logic signed [63:0] prod;
      prod = 64'(coord) * $signed({40'd0, inv_cell});
      return prod[63:32];
    endfunction

    function automatic logic [BUCKET_W-1:0] bucket_of(in_item_t it);
      logic [31:0] h;
      logic [31:0] m;
      h = (cell_index(it.pos_x) * PRIME_X) ^ (cell_index(it.pos_y) * PRIME_Y)
        ^ (cell_index(it.pos_z) * PRIME_Z);
      m = (tbl_size == 0) ? 32'd1 : {16'd0, tbl_size};
      return BUCKET_W'(h % m);
    endfunction

    function automatic void push(logic [ID_W-1:0] id, status_e st, logic lst);
      out_item_t r;
      r.neighbour_id = id;
      r.status = st;
      r.last = lst;
      pending.insert(pending.size(), r);
    endfunction

    function automatic void note_input(in_item_t it);
      logic [BUCKET_W-1:0] key;
      int unsigned lim;
      int n;
      n = 0;
      case (it.action)
        ACT_CLEAR: begin
          n_stored = 0;
          push('0, ST_CLEARED, 1'b1);
        end
        ACT_INSERT: begin
          if (n_stored >= MAX_ENTRIES) push('0, ST_FULL, 1'b1);
          else begin
            bucket_mem[n_stored] = bucket_of(it);
            ident_mem[n_stored] = it.particle_id;
            n_stored++;
            push('0, ST_INSERTED, 1'b1);
          end
        end
        ACT_QUERY: begin
          key = bucket_of(it);
          lim = (it.limit > MAX_RESULTS) ? MAX_RESULTS : it.limit;
          for (int i = 0; i < n_stored && n < lim; i++)
            if (bucket_mem[i] == key) begin
              push(ident_mem[i], ST_NEIGHBOUR, 1'b0);
              n++;
            end
          if (n == 0) push('0, ST_NONE, 1'b1);
          else pending[$].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    task automatic check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected", got, got);
        return;
      end
      want = pending.pop_front();
      if (got.neighbour_id !== want.neighbour_id) report("neighbour_id", got, want);
      if (got.status !== want.status) report("status", got, want);
      if (got.last !== want.last) report("last", got, want);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic hold_req = 1'b0;
  logic hold_off = 1'b0;
  longint unsigned cycles = 0;

  table_scoreboard sb = new();

  always #5 clk = ~clk;

  spatial_hash_neighbour_table_unit DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata)
  );

  // Receiver: random stall pattern, long hold-off on request.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    if (hold_off) out_stall <= 1'b1;
    else if ($urandom_range(0, 3) == 0) out_stall <= ($urandom_range(0, 1) == 1);
  end

  // Hold the receiver off for a fixed stretch once requested.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 10_000_000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send(input in_item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_INV_CELL) sb.inv_cell = val;
    else sb.tbl_size = val[BUCKET_W-1:0];
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos(int unsigned cells);
    logic [31:0] p;
    if ($urandom_range(0, 7) == 0) p = $urandom();
    else p = 32'($signed($urandom_range(0, 2 * cells)) - $signed(cells)) << 14;
    return p;
  endfunction

  function automatic in_item_t make_item(action_e act, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z, int unsigned id, int unsigned lim);
    in_item_t it;
    it.action = act;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.particle_id = ID_W'(id);
    it.limit = LIMIT_W'(lim);
    return it;
  endfunction

  function automatic in_item_t rand_item(int unsigned cells);
    int unsigned r;
    action_e act;
    in_item_t it;
    r = $urandom_range(0, 99);
    act = (r < 3) ? ACT_CLEAR : (r < 55) ? ACT_INSERT : ACT_QUERY;
    it = make_item(act, rand_pos(cells), rand_pos(cells), rand_pos(cells),
                   $urandom_range(0, 1023), $urandom_range(0, 127));
    if (r == 99) it.action = 2'd3;
    return it;
  endfunction

  task automatic random_phase(input int n, input int unsigned cells);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 1) == 1) pause_sender();
      end
      send(rand_item(cells));
      burst--;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every action, limits, unused code.
    send(make_item(ACT_QUERY, 0, 0, 0, 0, 64));
    send(make_item(ACT_INSERT, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1023, 0));
    send(make_item(ACT_INSERT, 32'h7fffffff, 32'h80000000, 32'hffffffff, 0, 127));
    send(make_item(ACT_INSERT, 0, 0, 0, 5, 1));
    send(make_item(ACT_QUERY, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1023, 127));
    send(make_item(ACT_QUERY, 32'h7fffffff, 32'h80000000, 32'hffffffff, 0, 1));
    send(make_item(ACT_QUERY, 32'h7fffffff, 32'h80000000, 32'hffffffff, 0, 0));
    send(make_item(ACT_QUERY, 32'h80000000, 32'h7fffffff, 0, 0, 64));
    send(make_item(action_e'(2'd3), 1, 2, 3, 4, 5));
    send(make_item(ACT_CLEAR, 0, 0, 0, 0, 0));
    send(make_item(ACT_QUERY, 0, 0, 0, 0, 64));
    drain();

    // Fill past capacity with a one-bucket table, then query deep; hold receiver off a while.
    write_reg(REG_TABLE_SIZE, 16'd1);
    write_reg(REG_INV_CELL, 24'hffffff);
    for (int i = 0; i < MAX_ENTRIES + 3; i++) begin
      if (i == 1010) hold_req = 1'b1;
      send(make_item(ACT_INSERT, $urandom(), $urandom(), $urandom(), $urandom_range(0, 1023), 0));
    end
    send(make_item(ACT_QUERY, 1, 2, 3, 0, 100));
    send(make_item(ACT_QUERY, 1, 2, 3, 0, 3));
    send(make_item(ACT_QUERY, 1, 2, 3, 0, 64));
    send(make_item(ACT_CLEAR, 0, 0, 0, 0, 0));
    drain();

    write_reg(REG_TABLE_SIZE, 16'd0);
    write_reg(REG_INV_CELL, 24'd0);
    random_phase(30, 100);
    drain();

    write_reg(REG_TABLE_SIZE, 16'd7);
    write_reg(REG_INV_CELL, 24'd1);
    random_phase(60, 1000);
    drain();

    write_reg(REG_INV_CELL, INV_CELL_RESET);
    write_reg(REG_TABLE_SIZE, 16'd65535);
    random_phase(80, 6);
    drain();

    write_reg(REG_TABLE_SIZE, 16'd31);
    write_reg(REG_INV_CELL, 24'h010000);
    random_phase(150, 8);
    drain();

    write_reg(REG_TABLE_SIZE, 16'd13); // change size with entries stored
    random_phase(80, 8);
    drain();

    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
